// File: src/ssr_pkg.sv
`timescale 1ns / 1ps

package ssr_pkg;

  // GF(2^8) field constants, reduction polynomial 0x11B
  localparam logic [7:0] GF_REDUCE    = 8'h1B;
  localparam logic [7:0] GF_TOP       = 8'h80;
  localparam logic [7:0] GF_ONE       = 8'h01;
  // inverse of a is a^254
  localparam logic [7:0] GF_INV_POWER = 8'd254;

  // sequencer step counter, covers both the share loop and the 8-bit exponent
  localparam int unsigned STEP_W = 3;

  // register map: register i at byte address 8*i, decoded on paddr[3]
  localparam int unsigned PADDR_W       = 4;
  localparam logic        REG_THRESHOLD = 1'b0;
  localparam logic        REG_SHARE_IDS = 1'b1;

  localparam logic [3:0] THRESHOLD_RESET = 4'd2;
  localparam logic [3:0] THRESHOLD_MIN   = 4'd2;

  // weight sequencer phases
  localparam logic [1:0] SEQ_IDLE = 2'd0;
  localparam logic [1:0] SEQ_PROD = 2'd1;
  localparam logic [1:0] SEQ_INV  = 2'd2;
  localparam logic [1:0] SEQ_FIN  = 2'd3;

  typedef struct packed {
    logic [1:0]        phase;
    logic [STEP_W-1:0] step;
  } seq_ctrl_t;

  typedef struct packed {
    logic [7:0] share_byte_0;
    logic [7:0] share_byte_1;
    logic [7:0] share_byte_2;
    logic [7:0] share_byte_3;
    logic [7:0] share_byte_4;
    logic [7:0] share_byte_5;
    logic [7:0] share_byte_6;
    logic [7:0] share_byte_7;
  } share_item_t;

  typedef struct packed {
    logic [7:0] recovered_byte;
    logic       id_clash;
  } secret_item_t;

  // shift-and-add multiply in GF(2^8)
  function automatic logic [7:0] gf_mul(input logic [7:0] a, input logic [7:0] b);
    logic [7:0] p;
    logic [7:0] s;
    p = '0;
    s = a;
    for (int k = 0; k < 8; k++) begin
      if (b[k]) begin
        p = p ^ s;
      end
      if ((s & GF_TOP) != 8'h00) begin
        s = (s << 1) ^ GF_REDUCE;
      end else begin
        s = s << 1;
      end
    end
    return p;
  endfunction

  // y-byte of one share by index
  function automatic logic [7:0] share_byte(input share_item_t item,
                                            input logic [STEP_W-1:0] idx);
    logic [7:0] y;
    case (idx)
      3'd0:    y = item.share_byte_0;
      3'd1:    y = item.share_byte_1;
      3'd2:    y = item.share_byte_2;
      3'd3:    y = item.share_byte_3;
      3'd4:    y = item.share_byte_4;
      3'd5:    y = item.share_byte_5;
      3'd6:    y = item.share_byte_6;
      default: y = item.share_byte_7;
    endcase
    return y;
  endfunction

endpackage

// File: src/ssr_lane.sv
`timescale 1ns / 1ps

// One share lane: builds the basis weight of its share over several cycles,
// then scales each incoming y-byte by that weight.
module ssr_lane #(
  parameter int unsigned LANE = 0
) (
  input  logic                  clk_i,
  input  ssr_pkg::seq_ctrl_t    ctrl_i,
  input  logic [3:0]            used_i,
  input  logic [63:0]           ids_i,
  input  logic                  take_i,
  input  logic [7:0]            y_i,
  output logic [7:0]            prod_o,
  output logic                  clash_o
);

  logic [7:0] num_q, num_d;
  logic [7:0] den_q, den_d;
  logic [7:0] inv_q, inv_d;
  logic [7:0] weight_q;
  logic       clash_q;
  logic [7:0] prod_q;

  logic [7:0] xi, xj;
  logic       use_j;
  logic       lane_used;
  logic [7:0] base_nd_num, base_nd_den, base_inv, sq;

  assign xi        = ids_i[8*LANE +: 8];
  assign xj        = ids_i[8*ctrl_i.step +: 8];
  assign use_j     = ({1'b0, ctrl_i.step} < used_i) &&
                     (ctrl_i.step != ssr_pkg::STEP_W'(LANE));
  assign lane_used = 4'(LANE) < used_i;

  // numerator prod x_j and denominator prod (x_i ^ x_j), one share a cycle
  always_comb begin
    base_nd_num = (ctrl_i.step == '0) ? ssr_pkg::GF_ONE : num_q;
    base_nd_den = (ctrl_i.step == '0) ? ssr_pkg::GF_ONE : den_q;
    num_d = num_q;
    den_d = den_q;
    if (ctrl_i.phase == ssr_pkg::SEQ_PROD) begin
      num_d = ssr_pkg::gf_mul(base_nd_num, use_j ? xj : ssr_pkg::GF_ONE);
      den_d = ssr_pkg::gf_mul(base_nd_den, use_j ? (xi ^ xj) : ssr_pkg::GF_ONE);
    end
  end

  // den^254 by square and multiply, exponent msb first
  always_comb begin
    base_inv = (ctrl_i.step == '0) ? ssr_pkg::GF_ONE : inv_q;
    sq       = ssr_pkg::gf_mul(base_inv, base_inv);
    inv_d    = inv_q;
    if (ctrl_i.phase == ssr_pkg::SEQ_INV) begin
      if (ssr_pkg::GF_INV_POWER[3'd7 - ctrl_i.step]) begin
        inv_d = ssr_pkg::gf_mul(sq, den_q);
      end else begin
        inv_d = sq;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    num_q <= num_d;
    den_q <= den_d;
    inv_q <= inv_d;
    // finish: weight and clash flag, unused lanes contribute nothing
    if (ctrl_i.phase == ssr_pkg::SEQ_FIN) begin
      weight_q <= lane_used ? ssr_pkg::gf_mul(num_q, inv_q) : 8'h00;
      clash_q  <= lane_used && (den_q == 8'h00);
    end
    if (take_i) begin
      prod_q <= ssr_pkg::gf_mul(y_i, weight_q);
    end
  end

  assign prod_o  = prod_q;
  assign clash_o = clash_q;

endmodule

// File: src/ssr_merge.sv
`timescale 1ns / 1ps

// Combines the lane products into the recovered byte and drives the result.
module ssr_merge #(
  parameter int unsigned MAX_SHARES = 8
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        valid_i,
  input  logic [MAX_SHARES-1:0][7:0]  prod_i,
  input  logic [MAX_SHARES-1:0]       clash_i,
  output ssr_pkg::secret_item_t       result_o,
  output logic                        valid_o
);

  ssr_pkg::secret_item_t result_q;
  logic                  valid_q;
  logic [7:0]            acc;
  logic                  clash;

  // addition in GF(2^8) is xor
  always_comb begin
    acc = '0;
    for (int i = 0; i < MAX_SHARES; i++) begin
      acc = acc ^ prod_i[i];
    end
    clash = |clash_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i) begin
      result_q.recovered_byte <= clash ? 8'h00 : acc;
      result_q.id_clash       <= clash;
    end
  end

  assign result_o = result_q;
  assign valid_o  = valid_q;

endmodule

// File: src/shamir_secret_recovery_gf256_top.sv
`timescale 1ns / 1ps

// Shamir secret recovery over GF(2^8): one secret byte per item, one item per
// clock. An item is taken when start is high and busy is low; its result is
// registered in the lane product stage, then in the merge stage, and appears
// on result_o for exactly one cycle, marked by result_valid_o, and must be
// captured then since the receiver cannot stall. Basis weights depend only on
// the registers, so each share lane works out its weight once: after reset and
// after every register write, busy stays high while the sequencer forms the
// numerator and denominator products over the shares, then the inverse by
// exponentiation, then a finish step. Once busy is low, the rate is set by the
// single lane multiply and the merge xor, one item every cycle. id_clash reports
// equal ids among the used shares, with the recovered byte then zero.
module shamir_secret_recovery_gf256_top #(
  parameter int unsigned MAX_SHARES = 8
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               start,
  output logic                               busy,
  input  ssr_pkg::share_item_t               item_i,
  output ssr_pkg::secret_item_t              result_o,
  output logic                               result_valid_o,
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [ssr_pkg::PADDR_W-1:0]        paddr,
  input  logic [63:0]                        pwdata,
  output logic [63:0]                        prdata,
  output logic                               pready
);

  logic [3:0]         threshold_q;
  logic [63:0]        share_ids_q;
  ssr_pkg::seq_ctrl_t seq_q;
  logic               take1_q;
  logic [3:0]         used;
  logic               cfg_wr;
  logic               take;

  logic [MAX_SHARES-1:0][7:0] lane_prod;
  logic [MAX_SHARES-1:0]      lane_clash;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;
  assign busy   = seq_q.phase != ssr_pkg::SEQ_IDLE;
  assign take   = start && !busy;

  // register file
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      threshold_q <= ssr_pkg::THRESHOLD_RESET;
      share_ids_q <= '0;
    end else if (cfg_wr) begin
      case (paddr[3])
        ssr_pkg::REG_THRESHOLD: threshold_q <= pwdata[3:0];
        ssr_pkg::REG_SHARE_IDS: share_ids_q <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3])
      ssr_pkg::REG_THRESHOLD: prdata = {60'd0, threshold_q};
      ssr_pkg::REG_SHARE_IDS: prdata = share_ids_q;
      default:                prdata = '0;
    endcase
  end

  // threshold saturates into 2..MAX_SHARES
  always_comb begin
    if (threshold_q < ssr_pkg::THRESHOLD_MIN) begin
      used = ssr_pkg::THRESHOLD_MIN;
    end else if (threshold_q > 4'(MAX_SHARES)) begin
      used = 4'(MAX_SHARES);
    end else begin
      used = threshold_q;
    end
  end

  // weight sequencer, restarted by reset and by any register write
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seq_q.phase <= ssr_pkg::SEQ_PROD;
      seq_q.step  <= '0;
    end else if (cfg_wr) begin
      seq_q.phase <= ssr_pkg::SEQ_PROD;
      seq_q.step  <= '0;
    end else begin
      case (seq_q.phase)
        ssr_pkg::SEQ_PROD: begin
          if (seq_q.step == ssr_pkg::STEP_W'(MAX_SHARES - 1)) begin
            seq_q.phase <= ssr_pkg::SEQ_INV;
            seq_q.step  <= '0;
          end else begin
            seq_q.step <= seq_q.step + 1'b1;
          end
        end
        ssr_pkg::SEQ_INV: begin
          if (seq_q.step == '1) begin
            seq_q.phase <= ssr_pkg::SEQ_FIN;
            seq_q.step  <= '0;
          end else begin
            seq_q.step <= seq_q.step + 1'b1;
          end
        end
        ssr_pkg::SEQ_FIN: begin
          seq_q.phase <= ssr_pkg::SEQ_IDLE;
        end
        default: begin
          seq_q.phase <= ssr_pkg::SEQ_IDLE;
          seq_q.step  <= '0;
        end
      endcase
    end
  end

  // item valid alongside the lane product stage
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      take1_q <= 1'b0;
    end else begin
      take1_q <= take;
    end
  end

  for (genvar g = 0; g < MAX_SHARES; g++) begin : g_lane
    ssr_lane #(
      .LANE (g)
    ) u_lane (
      .clk_i   (clk_i),
      .ctrl_i  (seq_q),
      .used_i  (used),
      .ids_i   (share_ids_q),
      .take_i  (take),
      .y_i     (ssr_pkg::share_byte(item_i, ssr_pkg::STEP_W'(g))),
      .prod_o  (lane_prod[g]),
      .clash_o (lane_clash[g])
    );
  end

  ssr_merge #(
    .MAX_SHARES (MAX_SHARES)
  ) u_merge (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .valid_i  (take1_q),
    .prod_i   (lane_prod),
    .clash_i  (lane_clash),
    .result_o (result_o),
    .valid_o  (result_valid_o)
  );

  // every result stems from an accepted item, registered through the lane product and merge stages
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> $past(start && !busy, 2))
    else $error("result without an accepted item");

  // a clash always clears the recovered byte
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && result_o.id_clash) |-> (result_o.recovered_byte == 8'h00))
    else $error("clash result with nonzero recovered byte");

  // a register write always triggers a weight rebuild
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (psel && penable && pwrite) |=> busy)
    else $error("register write did not restart weight sequencer");

  // outside reset, busy only rises on a register write
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(busy) |-> $past(psel && penable && pwrite))
    else $error("busy rose without a register write");

endmodule
